// ===== sv/nmea_gga_pkg.sv =====
package nmea_gga_pkg;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;

	// Sentence layout
	localparam int unsigned TYPE_POS  = 4;
	localparam logic [3:0]  COMMA_MAX = 4'd15;
	localparam logic [3:0]  LAT_COMMA = 4'd2;
	localparam logic [3:0]  LON_COMMA = 4'd4;
	localparam logic [3:0]  FIX_COMMA = 4'd6;

	// field_kind codes
	localparam logic [1:0] KIND_LAT = 2'd0;
	localparam logic [1:0] KIND_LON = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] kind;
		logic       valid;
		logic [7:0] code;
	} res_t;

endpackage

// ===== sv/nmea_gga_parse.sv =====
// Sentence tracker: per-byte state update and result forming.
module nmea_gga_parse #(
	parameter int unsigned SCAN_LIMIT = 100,
	parameter int unsigned LAT_MAX    = 9,
	parameter int unsigned LON_MAX    = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output logic                res_vld,
	output nmea_gga_pkg::res_t  res
);

	localparam int unsigned PW = $clog2(SCAN_LIMIT + 1);
	localparam int unsigned AW = $clog2(LAT_MAX + 1);
	localparam int unsigned OW = $clog2(LON_MAX + 1);

	logic [PW-1:0] pos_q, pos_n;
	logic [3:0]    cc_q, cc_n;
	logic          in_q, in_n;
	logic          gga_q, gga_n;
	logic [AW-1:0] lat_q, lat_n;
	logic [OW-1:0] lon_q, lon_n;
	logic [7:0]    fix_q, fix_n;
	logic          pend_q, pend_n;

	always_comb begin
		pos_n   = pos_q;
		cc_n    = cc_q;
		in_n    = in_q;
		gga_n   = gga_q;
		lat_n   = lat_q;
		lon_n   = lon_q;
		fix_n   = fix_q;
		pend_n  = pend_q;
		res_vld = 1'b0;
		res     = '0;
		if (rx_byte == nmea_gga_pkg::CH_NUL) begin
			// ignored
		end else if (rx_byte == nmea_gga_pkg::CH_START) begin
			in_n   = 1'b1;
			pos_n  = PW'(1);
			cc_n   = '0;
			gga_n  = 1'b0;
			lat_n  = '0;
			lon_n  = '0;
			pend_n = 1'b0;
		end else if (in_q) begin
			if (pend_q) begin
				fix_n  = rx_byte;
				pend_n = 1'b0;
			end
			if (rx_byte == nmea_gga_pkg::CH_LF) begin
				if (gga_q) begin
					res_vld    = 1'b1;
					res.kind   = nmea_gga_pkg::KIND_END;
					res.code   = fix_n;
					res.valid  = (fix_n == nmea_gga_pkg::CH_ONE) ||
					             (fix_n == nmea_gga_pkg::CH_TWO);
				end
				in_n   = 1'b0;
				gga_n  = 1'b0;
				pend_n = 1'b0;
			end else begin
				if (pos_q == PW'(nmea_gga_pkg::TYPE_POS) && rx_byte == nmea_gga_pkg::CH_G)
					gga_n = 1'b1;
				if (pos_q < PW'(SCAN_LIMIT)) begin
					if (rx_byte == nmea_gga_pkg::CH_COMMA) begin
						if (cc_q < nmea_gga_pkg::COMMA_MAX) begin
							cc_n = cc_q + 4'd1;
							if (cc_n == nmea_gga_pkg::FIX_COMMA && gga_n)
								pend_n = 1'b1;
						end
					end else if (gga_n) begin
						if (cc_q == nmea_gga_pkg::LAT_COMMA && lat_q < AW'(LAT_MAX)) begin
							lat_n    = lat_q + AW'(1);
							res_vld  = 1'b1;
							res.ch   = rx_byte;
							res.kind = nmea_gga_pkg::KIND_LAT;
						end else if (cc_q == nmea_gga_pkg::LON_COMMA &&
						             lon_q < OW'(LON_MAX)) begin
							lon_n    = lon_q + OW'(1);
							res_vld  = 1'b1;
							res.ch   = rx_byte;
							res.kind = nmea_gga_pkg::KIND_LON;
						end
					end
					pos_n = pos_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cc_q   <= '0;
			in_q   <= 1'b0;
			gga_q  <= 1'b0;
			lat_q  <= '0;
			lon_q  <= '0;
			fix_q  <= nmea_gga_pkg::CH_ZERO;
			pend_q <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_n;
			cc_q   <= cc_n;
			in_q   <= in_n;
			gga_q  <= gga_n;
			lat_q  <= lat_n;
			lon_q  <= lon_n;
			fix_q  <= fix_n;
			pend_q <= pend_n;
		end
	end

endmodule

// ===== sv/nmea_gga_out_reg.sv =====
// Result register; frees in the same cycle the beat is taken.
module nmea_gga_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  nmea_gga_pkg::res_t  res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output nmea_gga_pkg::res_t  res_q
);

	logic vld_q;

	assign room      = !vld_q || out_ready;
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (room) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load)
			res_q <= res;
	end

endmodule

// ===== sv/nmea_gga_position_extractor_unit.sv =====
// NMEA 0183 GGA position extractor. Takes one receiver byte per beat on the
// in channel and returns latitude and longitude characters of GGA sentences,
// one per beat on the out channel, followed on LF by an end marker that
// carries the last captured fix quality character and whether it is '1' or
// '2'. Throughput is one byte per clock when the out channel does not stall.
// An accepted byte is held in the input register until the result register
// has room, then its result is loaded into the result register and shown on
// the out channel. Bytes that produce no result still pass through the input
// register and update the sentence state. Output stalls back-pressure the
// input only once both the input register and the result register are full.
module nmea_gga_position_extractor_unit #(
	parameter int unsigned SCAN_LIMIT = 100,
	parameter int unsigned LAT_MAX    = 9,
	parameter int unsigned LON_MAX    = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic [1:0] field_kind,
	output logic       fix_valid,
	output logic [7:0] fix_code
);

	// input register
	logic       vld_s1;
	logic [7:0] byte_s1;

	logic               room;
	logic               step;
	logic               res_vld;
	nmea_gga_pkg::res_t res;
	nmea_gga_pkg::res_t res_q;

	// byte in stage 1 moves on whenever the result slot can take it
	assign step     = vld_s1 && room;
	assign in_ready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	nmea_gga_parse #(
		.SCAN_LIMIT (SCAN_LIMIT),
		.LAT_MAX    (LAT_MAX),
		.LON_MAX    (LON_MAX)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	nmea_gga_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_vld),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign out_char   = res_q.ch;
	assign field_kind = res_q.kind;
	assign fix_valid  = res_q.valid;
	assign fix_code   = res_q.code;

endmodule

// ===== sv/nmea_gga_chk.sv =====
module nmea_gga_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic [1:0] field_kind,
	input logic       fix_valid,
	input logic [7:0] fix_code
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) &&
		$stable(field_kind) && $stable(fix_valid) && $stable(fix_code))
		else $error("result beat changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_kind == nmea_gga_pkg::KIND_LAT ||
		field_kind == nmea_gga_pkg::KIND_LON || field_kind == nmea_gga_pkg::KIND_END)
		else $error("illegal field_kind");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind != nmea_gga_pkg::KIND_END |-> !fix_valid && fix_code == 8'd0)
		else $error("fix fields set on a character beat");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == nmea_gga_pkg::KIND_END |-> out_char == 8'd0)
		else $error("end marker carries a character");

	a_fix_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == nmea_gga_pkg::KIND_END |->
		fix_valid == (fix_code == nmea_gga_pkg::CH_ONE || fix_code == nmea_gga_pkg::CH_TWO))
		else $error("fix_valid disagrees with fix_code");

endmodule

bind nmea_gga_position_extractor_unit nmea_gga_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_char   (out_char),
	.field_kind (field_kind),
	.fix_valid  (fix_valid),
	.fix_code   (fix_code)
);
